### rtl/sbppc_pkg.sv
// Shared types, register indexes and constants of the stepped boiler pressure power control.
package sbppc_pkg;

  // Field widths.
  localparam int PRESSURE_BITS  = 12;
  localparam int OFFSET_BITS    = 8;
  localparam int POWER_BITS     = 7;
  localparam int MAX_POWER_BITS = 8;
  localparam int TIME_BITS      = 16;

  // Default offset added to the setpoint on phase-change devices.
  localparam int DEFAULT_PHASE_OFFSET = 65;

  // Configuration port.
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = PRESSURE_BITS;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_SET_PRESSURE   = cfg_idx_t'(0);
  localparam cfg_idx_t REG_STOP_PRESSURE  = cfg_idx_t'(1);
  localparam cfg_idx_t REG_MIN_POWER      = cfg_idx_t'(2);
  localparam cfg_idx_t REG_MAX_POWER      = cfg_idx_t'(3);
  localparam cfg_idx_t REG_PHASE_DEVICE   = cfg_idx_t'(4);
  localparam cfg_idx_t REG_CONTROL_VARIANT = cfg_idx_t'(5);

  // Register values after reset.
  localparam logic [PRESSURE_BITS-1:0]  RST_SET_PRESSURE  = PRESSURE_BITS'(100);
  localparam logic [PRESSURE_BITS-1:0]  RST_STOP_PRESSURE = PRESSURE_BITS'(150);
  localparam logic [POWER_BITS-1:0]     RST_MIN_POWER     = POWER_BITS'(15);
  localparam logic [MAX_POWER_BITS-1:0] RST_MAX_POWER     = MAX_POWER_BITS'(100);

  // Control thresholds.
  localparam logic [TIME_BITS-1:0]      FAST_ON_TIME  = TIME_BITS'(6);
  localparam logic [TIME_BITS-1:0]      FAST_OFF_TIME = TIME_BITS'(5);
  localparam logic [POWER_BITS-1:0]     HOLD_POWER    = POWER_BITS'(80);
  localparam logic [POWER_BITS-1:0]     TRIM_POWER    = POWER_BITS'(70);
  localparam logic [PRESSURE_BITS:0]    BAND_STEP     = (PRESSURE_BITS+1)'(2);
  localparam logic [PRESSURE_BITS:0]    BAND_LOW      = (PRESSURE_BITS+1)'(10);
  localparam logic [MAX_POWER_BITS-1:0] POWER_CAP     = MAX_POWER_BITS'(100);
  localparam logic [MAX_POWER_BITS-1:0] MAX_FLOOR     = MAX_POWER_BITS'(20);
  localparam logic [MAX_POWER_BITS-1:0] MAX_DEFAULT   = MAX_POWER_BITS'(25);

  // Input word.
  typedef struct packed {
    logic                     one_sec_tick;
    logic                     five_sec_tick;
    logic                     rate_tick;
    logic                     flame_on;
    logic [PRESSURE_BITS-1:0] outlet_pressure;
    logic [PRESSURE_BITS-1:0] high_side_pressure;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [POWER_BITS-1:0] power_percent;
    logic                  overpressure_trip;
    logic [TIME_BITS-1:0]  change_time;
  } out_word_t;

endpackage

### rtl/stepped_boiler_pressure_power_control.sv
// Top level of the stepped boiler pressure power control.
//
// Takes one word of ticks, flame flag and pressures, steps the burner power by one
// percent on pending one-second or five-second ticks (after any drop to the hold or
// trim level) and returns one word with the clamped power, the overpressure trip and
// the last measured change time. The output register is loaded from the control step,
// which follows the rate step directly, or after a 16-step shift-and-subtract divider,
// one quotient bit per cycle, when a rate tick sees a pressure change. The block takes
// no new word while one is in work. Once a result sits in the output register the
// next word can be accepted in that same cycle, and a finished result waits in the
// control step until the output register is free.
module stepped_boiler_pressure_power_control #(
  parameter int unsigned PHASE_OFFSET = sbppc_pkg::DEFAULT_PHASE_OFFSET
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  sbppc_pkg::in_word_t                  in_word_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output sbppc_pkg::out_word_t                 out_word_o,
  input  logic                                 cfg_we_i,
  input  sbppc_pkg::cfg_idx_t                  cfg_idx_i,
  input  logic [sbppc_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i
);
  import sbppc_pkg::*;

  localparam int PW1 = PRESSURE_BITS + 1;
  localparam int CNT_BITS = $clog2(TIME_BITS);
  localparam logic [OFFSET_BITS-1:0] OFFSET_C = OFFSET_BITS'(PHASE_OFFSET);
  localparam logic [CNT_BITS-1:0] DIV_LAST = CNT_BITS'(TIME_BITS - 1);
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  typedef enum logic [1:0] {ST_IDLE, ST_RATE, ST_DIV, ST_CTRL} state_e;

  // Control state and registers.
  state_e                     state_q, state_d;
  logic [PRESSURE_BITS-1:0]   set_q, stop_q;
  logic [POWER_BITS-1:0]      min_q;
  logic [MAX_POWER_BITS-1:0]  max_q;
  logic                       phase_q, variant_q;
  logic [POWER_BITS-1:0]      power_q, power_d;
  logic                       fast_q, fast_d;
  logic                       pend1_q, pend1_d, pend5_q, pend5_d;
  logic [PRESSURE_BITS-1:0]   prev_q, prev_d;
  logic [TIME_BITS-1:0]       timer_q, timer_d;
  logic [TIME_BITS-1:0]       mct_q, mct_d;
  logic                       out_valid_q, out_valid_d;
  out_word_t                  out_word_q, out_word_d;

  // Latched item and divider registers.
  logic                       rate_q, flame_q;
  logic [PRESSURE_BITS-1:0]   p_q, hs_q;
  logic [PRESSURE_BITS-1:0]   rem_q, rem_d, den_q, den_d;
  logic [TIME_BITS-1:0]       quo_q, quo_d;
  logic [CNT_BITS-1:0]        cnt_q, cnt_d;

  logic accept, out_free;
  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // Real pressure and the offset setpoint and stop limits.
  logic [PRESSURE_BITS-1:0] r;
  logic [PW1-1:0] off_ext, m, stop_m, r_ext, p_ext;
  assign r       = phase_q ? hs_q : p_q;
  assign off_ext = phase_q ? PW1'(OFFSET_C) : '0;
  assign m       = {1'b0, set_q} + off_ext;
  assign stop_m  = {1'b0, stop_q} + off_ext;
  assign r_ext   = {1'b0, r};
  assign p_ext   = {1'b0, p_q};

  // Rate measurement helpers.
  logic [TIME_BITS-1:0]     timer_inc;
  logic [PRESSURE_BITS-1:0] diff;
  assign timer_inc = (timer_q == TIME_MAX) ? timer_q : timer_q + TIME_BITS'(1);
  assign diff      = (r > prev_q) ? (r - prev_q) : (prev_q - r);

  // One shift-and-subtract step of the divider.
  logic [PW1-1:0]       trial, trial_sub;
  logic                 fits;
  logic [PRESSURE_BITS-1:0] rem_step;
  logic [TIME_BITS-1:0] quo_step;
  assign trial     = {rem_q, quo_q[TIME_BITS-1]};
  assign fits      = trial >= {1'b0, den_q};
  assign trial_sub = trial - {1'b0, den_q};
  assign rem_step  = fits ? trial_sub[PRESSURE_BITS-1:0] : trial[PRESSURE_BITS-1:0];
  assign quo_step  = {quo_q[TIME_BITS-2:0], fits};

  // Pressure comparisons for the power step.
  logic below, at_set, r_hi, p_gt, p_ge, p_ge2, r_lo, old_hi;
  assign below  = (p_q < set_q) && (r_ext < m);
  assign at_set = (r_ext == m);
  assign r_hi   = (r_ext > m);
  assign p_gt   = (p_q > set_q);
  assign p_ge   = (p_q >= set_q);
  assign p_ge2  = (p_ext >= ({1'b0, set_q} + BAND_STEP));
  assign r_lo   = ((r_ext + BAND_LOW) <= m);
  assign old_hi = (power_q > HOLD_POWER);

  // Fast-ramp flag as seen by the step logic.
  logic fast_mid;
  always_comb begin
    fast_mid = fast_q;
    if (below) begin
      if (mct_q > FAST_ON_TIME) fast_mid = 1'b1;
      if (mct_q <= FAST_OFF_TIME) fast_mid = 1'b0;
    end
    if (at_set) fast_mid = 1'b1;
  end

  // Step decisions and consumed ticks.
  logic up_fast, up_slow, up_band, dn_branch, down, up, trim;
  assign up_fast   = below && fast_mid && pend1_q;
  assign up_slow   = below && !fast_mid && pend5_q;
  assign up_band   = variant_q && p_ge && !r_hi && !p_ge2 && r_lo && pend1_q;
  assign dn_branch = variant_q ? ((p_ge && (r_hi || p_ge2)) || (!p_ge && r_hi))
                               : (p_gt || r_hi);
  assign down      = pend1_q && dn_branch;
  assign up        = up_fast || up_slow || up_band;
  assign trim      = r_hi && (variant_q ? p_ge : p_gt) && old_hi;

  // New power level before and after the clamp.
  logic [MAX_POWER_BITS-1:0] t_base, t_step, amax, t_max, t_fin;
  always_comb begin
    t_base = {1'b0, power_q};
    if (at_set && old_hi) t_base = {1'b0, HOLD_POWER};
    if (trim) t_base = {1'b0, TRIM_POWER};
    if (up) begin
      t_step = t_base + MAX_POWER_BITS'(1);
    end else if (down) begin
      t_step = (t_base == '0) ? '0 : t_base - MAX_POWER_BITS'(1);
    end else begin
      t_step = t_base;
    end
    if (max_q >= POWER_CAP) begin
      amax = POWER_CAP;
    end else if (max_q < MAX_FLOOR) begin
      amax = MAX_DEFAULT;
    end else begin
      amax = max_q;
    end
    t_max = (t_step > amax) ? amax : t_step;
    t_fin = (t_max < {1'b0, min_q}) ? {1'b0, min_q} : t_max;
  end

  logic trip;
  assign trip = (r_ext >= stop_m) || (p_q >= stop_q);

  // Sequencer next state.
  always_comb begin
    state_d     = state_q;
    power_d     = power_q;
    fast_d      = fast_q;
    pend1_d     = pend1_q;
    pend5_d     = pend5_q;
    prev_d      = prev_q;
    timer_d     = timer_q;
    mct_d       = mct_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_word_d  = out_word_q;
    rem_d       = rem_q;
    den_d       = den_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          pend1_d = pend1_q || in_word_i.one_sec_tick;
          pend5_d = pend5_q || in_word_i.five_sec_tick;
          state_d = ST_RATE;
        end
      end
      ST_RATE: begin
        state_d = ST_CTRL;
        if (rate_q) begin
          if (flame_q) begin
            timer_d = timer_inc;
            if (r != prev_q) begin
              // Start the divider on timer / pressure difference.
              prev_d  = r;
              timer_d = '0;
              rem_d   = '0;
              den_d   = diff;
              quo_d   = timer_inc;
              cnt_d   = DIV_LAST;
              state_d = ST_DIV;
            end
          end else begin
            prev_d  = r;
            timer_d = '0;
            mct_d   = '0;
          end
        end
      end
      ST_DIV: begin
        rem_d = rem_step;
        quo_d = quo_step;
        cnt_d = cnt_q - CNT_BITS'(1);
        if (cnt_q == '0) begin
          mct_d   = quo_step;
          state_d = ST_CTRL;
        end
      end
      ST_CTRL: begin
        // Commit the step once the output register can take the result.
        if (out_free) begin
          power_d     = t_fin[POWER_BITS-1:0];
          fast_d      = fast_mid || (t_fin[POWER_BITS-1:0] >= TRIM_POWER);
          pend1_d     = pend1_q && !(up_fast || up_band || down);
          pend5_d     = pend5_q && !up_slow;
          out_valid_d = 1'b1;
          out_word_d.power_percent     = t_fin[POWER_BITS-1:0];
          out_word_d.overpressure_trip = trip;
          out_word_d.change_time       = mct_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State, configuration and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      set_q       <= RST_SET_PRESSURE;
      stop_q      <= RST_STOP_PRESSURE;
      min_q       <= RST_MIN_POWER;
      max_q       <= RST_MAX_POWER;
      phase_q     <= 1'b0;
      variant_q   <= 1'b0;
      power_q     <= '0;
      fast_q      <= 1'b0;
      pend1_q     <= 1'b0;
      pend5_q     <= 1'b0;
      prev_q      <= '0;
      timer_q     <= '0;
      mct_q       <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
    end else begin
      state_q     <= state_d;
      power_q     <= power_d;
      fast_q      <= fast_d;
      pend1_q     <= pend1_d;
      pend5_q     <= pend5_d;
      prev_q      <= prev_d;
      timer_q     <= timer_d;
      mct_q       <= mct_d;
      out_valid_q <= out_valid_d;
      out_word_q  <= out_word_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SET_PRESSURE:    set_q     <= cfg_wdata_i[PRESSURE_BITS-1:0];
          REG_STOP_PRESSURE:   stop_q    <= cfg_wdata_i[PRESSURE_BITS-1:0];
          REG_MIN_POWER:       min_q     <= cfg_wdata_i[POWER_BITS-1:0];
          REG_MAX_POWER:       max_q     <= cfg_wdata_i[MAX_POWER_BITS-1:0];
          REG_PHASE_DEVICE:    phase_q   <= cfg_wdata_i[0];
          REG_CONTROL_VARIANT: variant_q <= cfg_wdata_i[0];
          default: begin
          end
        endcase
      end
    end
  end

  // Item capture and divider working registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rate_q  <= in_word_i.rate_tick;
      flame_q <= in_word_i.flame_on;
      p_q     <= in_word_i.outlet_pressure;
      hs_q    <= in_word_i.high_side_pressure;
    end
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
    cnt_q <= cnt_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

### rtl/sbppc_checker.sv
// Port-level checks of the stepped boiler pressure power control, bound to its top level.
module sbppc_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input sbppc_pkg::out_word_t out_word_o
);

  // A held result keeps its word until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_word_o)))
    else $error("result word changed while stalled");

  // An accepted word keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block not busy after accepting a word");

  // A new result appears together with the return to the ready state.
  a_ready_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("result posted while the block stays busy");

  // Once reset has been seen at a clock edge, no result is shown in the next cycle.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind stepped_boiler_pressure_power_control sbppc_checker u_sbppc_checker (.*);

### bench/tb_stepped_boiler_pressure_power_control.sv
// Self-checking testbench for the stepped boiler pressure power control.
module tb_stepped_boiler_pressure_power_control;
  timeunit 1ns;
  timeprecision 1ps;

  import sbppc_pkg::*;

  localparam int          CLK_PERIOD    = 4;
  localparam int          RESET_CYCLES  = 9;
  localparam int unsigned PHASE_OFF     = DEFAULT_PHASE_OFFSET;
  localparam int          PRESSURE_MAX  = (1 << PRESSURE_BITS) - 1;
  localparam int          TIME_MAX      = (1 << TIME_BITS) - 1;
  localparam int          LIMIT_CYCLES  = 200000;
  localparam int          HOLD_PHASE    = 1;
  localparam int          NO_IDLE_PHASE = 3;
  localparam int          LONG_HOLD     = 80;
  localparam int          SETTLE_CYCLES = 40;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  in_word_t                 in_word = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  out_word_t                out_word;
  logic                     cfg_we = 1'b0;
  cfg_idx_t                 cfg_idx = REG_SET_PRESSURE;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  // Words waiting to be offered and results still owed by the block.
  in_word_t  pending_words[$];
  out_word_t expected_words[$];
  logic      word_taken = 1'b0;

  int idle_pct = 11;
  int phase_no = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int words_sent = 0;
  int results_checked = 0;
  int trips_seen = 0;

  // Register copy used by the predictor.
  int unsigned set_p, stop_p, min_pwr, max_pwr;
  bit          phase_dev, variant;

  // Controller state as the predictor tracks it.
  int unsigned burner_power, last_pressure, rate_count, change_time_q;
  bit          fast_ramp_q, tick1_pending, tick5_pending;

  // Pressures of the last generated word, reused for slow-changing stretches.
  logic [PRESSURE_BITS-1:0] gen_p, gen_hs;

  stepped_boiler_pressure_power_control #(
    .PHASE_OFFSET(PHASE_OFF)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Consume a latched one-second tick if there is one.
  function automatic bit take_one_sec();
    if (tick1_pending) begin
      tick1_pending = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int unsigned step_down(int unsigned v);
    return (v != 0) ? v - 1 : 0;
  endfunction

  // Work out the result word for one accepted input word and queue it.
  function automatic void predict_power(in_word_t w);
    int unsigned p, hs, r, s, off, m, prev, t, cap, diff;
    out_word_t   res;
    p    = w.outlet_pressure;
    hs   = w.high_side_pressure;
    s    = set_p;
    off  = phase_dev ? PHASE_OFF : 0;
    r    = phase_dev ? hs : p;
    m    = s + off;
    prev = burner_power;
    t    = prev;

    if (w.one_sec_tick) tick1_pending = 1'b1;
    if (w.five_sec_tick) tick5_pending = 1'b1;

    // Change time: ticks elapsed divided by the pressure difference.
    if (w.rate_tick) begin
      if (w.flame_on) begin
        if (rate_count < TIME_MAX) rate_count++;
        if (r != last_pressure) begin
          diff = (r > last_pressure) ? r - last_pressure : last_pressure - r;
          change_time_q = rate_count / diff;
          last_pressure = r;
          rate_count = 0;
        end
      end else begin
        last_pressure = r;
        rate_count = 0;
        change_time_q = 0;
      end
    end

    // Below the setpoint the power ramps up, fast or slow.
    if (p < s && r < m) begin
      if (change_time_q > FAST_ON_TIME) fast_ramp_q = 1'b1;
      if (change_time_q <= FAST_OFF_TIME) fast_ramp_q = 1'b0;
      if (fast_ramp_q) begin
        if (take_one_sec()) t++;
      end else if (tick5_pending) begin
        tick5_pending = 1'b0;
        t++;
      end
    end

    // At the setpoint the power is held at or below the hold level.
    if (r == m) begin
      if (prev > HOLD_POWER) t = HOLD_POWER;
      fast_ramp_q = 1'b1;
    end

    if (!variant) begin
      if (p > s) begin
        if (r > m && prev > HOLD_POWER) t = TRIM_POWER;
        if (take_one_sec()) t = step_down(t);
      end else if (r > m) begin
        if (take_one_sec()) t = step_down(t);
      end
    end else begin
      if (p >= s) begin
        if (r > m) begin
          if (prev > HOLD_POWER) t = TRIM_POWER;
          if (take_one_sec()) t = step_down(t);
        end else if (p >= s + BAND_STEP) begin
          if (take_one_sec()) t = step_down(t);
        end else if (r + BAND_LOW <= m) begin
          if (take_one_sec()) t++;
        end
      end else if (r > m) begin
        if (take_one_sec()) t = step_down(t);
      end
    end

    // Clamp: the minimum is applied last and wins over the maximum.
    cap = max_pwr;
    if (cap >= POWER_CAP) cap = POWER_CAP;
    if (cap < MAX_FLOOR) cap = MAX_DEFAULT;
    if (t > cap) t = cap;
    if (t < min_pwr) t = min_pwr;
    burner_power = t & 'h7F;
    if (burner_power >= TRIM_POWER) fast_ramp_q = 1'b1;

    res.power_percent     = POWER_BITS'(burner_power);
    res.overpressure_trip = (r >= stop_p + off) || (p >= stop_p);
    res.change_time       = TIME_BITS'(change_time_q);
    expected_words.push_back(res);
  endfunction

  // Input side: offer the next word at the falling edge, hold it while stalled.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !word_taken) begin
      in_valid <= 1'b1;
    end else if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
      in_valid <= 1'b1;
      in_word  <= pending_words[0];
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Output side: random stall, plus one long hold-off in one phase.
  int  hold_left = 0;
  bit  long_hold_done = 1'b0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (phase_no == HOLD_PHASE && !long_hold_done && out_valid) begin
      hold_left = LONG_HOLD;
      long_hold_done = 1'b1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  // Monitor: predict on each accepted input word, check each accepted result.
  always @(posedge clk) begin
    out_word_t want;
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles.", cycle_count);
      $display("stepped_boiler_pressure_power_control regression: fail");
      $finish;
    end else if (rst_n) begin
      word_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        predict_power(in_word);
        void'(pending_words.pop_front());
        words_sent++;
      end
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("result word with no word outstanding: %h", out_word);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          results_checked++;
          if (out_word.overpressure_trip) trips_seen++;
          if (out_word.power_percent !== want.power_percent) begin
            $error("power_percent: expected %0d, got %0d",
                   want.power_percent, out_word.power_percent);
            fail_count++;
          end
          if (out_word.overpressure_trip !== want.overpressure_trip) begin
            $error("overpressure_trip: expected %0d, got %0d",
                   want.overpressure_trip, out_word.overpressure_trip);
            fail_count++;
          end
          if (out_word.change_time !== want.change_time) begin
            $error("change_time: expected %0d, got %0d",
                   want.change_time, out_word.change_time);
            fail_count++;
          end
        end
      end
    end
  end

  function automatic in_word_t make_word(bit one, bit five, bit rate, bit flame,
                                         int unsigned p, int unsigned hs);
    in_word_t w;
    w.one_sec_tick       = one;
    w.five_sec_tick      = five;
    w.rate_tick          = rate;
    w.flame_on           = flame;
    w.outlet_pressure    = PRESSURE_BITS'(p);
    w.high_side_pressure = PRESSURE_BITS'(hs);
    return w;
  endfunction

  function automatic logic [PRESSURE_BITS-1:0] near_pressure(int center, int spread);
    int v;
    v = center + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > PRESSURE_MAX) v = PRESSURE_MAX;
    return PRESSURE_BITS'(v);
  endfunction

  // Write one register at a falling edge while the block is idle.
  task automatic write_reg(cfg_idx_t idx, int unsigned val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= CFG_DATA_BITS'(val);
    case (idx)
      REG_SET_PRESSURE:    set_p     = val & PRESSURE_MAX;
      REG_STOP_PRESSURE:   stop_p    = val & PRESSURE_MAX;
      REG_MIN_POWER:       min_pwr   = val & 'h7F;
      REG_MAX_POWER:       max_pwr   = val & 'hFF;
      REG_PHASE_DEVICE:    phase_dev = val[0];
      REG_CONTROL_VARIANT: variant   = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(int unsigned sp, int unsigned stp, int unsigned mn,
                               int unsigned mx, bit dev, bit var_sel);
    write_reg(REG_SET_PRESSURE, sp);
    write_reg(REG_STOP_PRESSURE, stp);
    write_reg(REG_MIN_POWER, mn);
    write_reg(REG_MAX_POWER, mx);
    write_reg(REG_PHASE_DEVICE, dev);
    write_reg(REG_CONTROL_VARIANT, var_sel);
  endtask

  // Sender pause: nothing new is offered until every result is back.
  task automatic wait_drained();
    while (pending_words.size() != 0 || expected_words.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Random words: mostly pressures around the setpoint that drift slowly, so the
  // change-time measurement and both ramp speeds get exercised; the rest near the
  // shutdown limit, fully random or at the extremes.
  task automatic load_random(int count);
    int          roll;
    int unsigned off;
    @(posedge clk);
    off = phase_dev ? PHASE_OFF : 0;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 35) begin
        // keep the previous pressures
      end else if (roll < 75) begin
        gen_p  = near_pressure(set_p, 12);
        gen_hs = near_pressure(set_p + off, 12);
      end else if (roll < 85) begin
        gen_p  = near_pressure(stop_p, 4);
        gen_hs = near_pressure(stop_p + off, 4);
      end else if (roll < 92) begin
        gen_p  = PRESSURE_BITS'($urandom_range(PRESSURE_MAX));
        gen_hs = PRESSURE_BITS'($urandom_range(PRESSURE_MAX));
      end else begin
        gen_p  = $urandom_range(1) ? PRESSURE_BITS'(PRESSURE_MAX) : '0;
        gen_hs = $urandom_range(1) ? PRESSURE_BITS'(PRESSURE_MAX) : '0;
      end
      pending_words.push_back(make_word($urandom_range(99) < 50, $urandom_range(99) < 30,
                                        $urandom_range(99) < 45, $urandom_range(99) < 85,
                                        gen_p, gen_hs));
    end
  endtask

  // One register setting: two batches with a full drain in between.
  task automatic run_phase(int count);
    load_random(count / 2);
    wait_drained();
    load_random(count - count / 2);
    wait_drained();
  endtask

  initial begin
    set_p = RST_SET_PRESSURE;  stop_p = RST_STOP_PRESSURE;
    min_pwr = RST_MIN_POWER;   max_pwr = RST_MAX_POWER;
    phase_dev = 1'b0;          variant = 1'b0;
    burner_power = 0;  last_pressure = 0;  rate_count = 0;  change_time_q = 0;
    fast_ramp_q = 1'b0;  tick1_pending = 1'b0;  tick5_pending = 1'b0;
    gen_p = 12'd100;  gen_hs = 12'd100;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // Directed words on the reset settings: tick latching, slow and fast ramp,
    // measurement with and without flame, setpoint, step down, trip edges.
    @(posedge clk);
    pending_words.push_back(make_word(0, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(1, 0, 0, 1, 50, 0));
    pending_words.push_back(make_word(0, 1, 0, 1, 50, 0));
    pending_words.push_back(make_word(0, 0, 1, 0, 50, PRESSURE_MAX));
    repeat (7) pending_words.push_back(make_word(0, 0, 1, 1, 50, 0));
    pending_words.push_back(make_word(0, 0, 1, 1, 51, 0));
    pending_words.push_back(make_word(1, 0, 0, 1, 60, 0));
    pending_words.push_back(make_word(1, 1, 1, 1, 40, 0));
    pending_words.push_back(make_word(0, 0, 0, 1, 100, 0));
    pending_words.push_back(make_word(1, 0, 0, 1, 120, 0));
    pending_words.push_back(make_word(1, 0, 0, 1, 149, 0));
    pending_words.push_back(make_word(1, 0, 0, 1, 150, 0));
    pending_words.push_back(make_word(0, 0, 0, 1, PRESSURE_MAX, PRESSURE_MAX));
    pending_words.push_back(make_word(1, 1, 1, 1, PRESSURE_MAX, PRESSURE_MAX));
    pending_words.push_back(make_word(1, 1, 1, 1, 0, PRESSURE_MAX));
    pending_words.push_back(make_word(0, 0, 0, 0, 0, PRESSURE_MAX));
    wait_drained();
    run_phase(70);

    // Phase-change device, widest power range; the receiver holds off once here.
    phase_no = HOLD_PHASE;
    apply_setting(100, PRESSURE_MAX, 0, 255, 1, 0);
    run_phase(75);

    // Minimum above the maximum, balance thresholds, trip always set.
    phase_no = 2;
    apply_setting(2000, 0, 100, 0, 0, 1);
    run_phase(75);

    // Zero setpoint, low maximum, no idling on either side.
    phase_no = NO_IDLE_PHASE;
    idle_pct = 0;
    apply_setting(0, PRESSURE_MAX, 0, 19, 1, 1);
    run_phase(75);
    idle_pct = 11;

    // Top setpoint with the offset pushing the target past the pressure range.
    phase_no = 4;
    apply_setting(PRESSURE_MAX, PRESSURE_MAX, 15, 100, 1, 1);
    run_phase(75);

    // Random settings.
    phase_no = 5;
    apply_setting($urandom_range(PRESSURE_MAX), $urandom_range(PRESSURE_MAX),
                  $urandom_range(100), $urandom_range(255),
                  $urandom_range(1), $urandom_range(1));
    run_phase(75);

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_words.size() != 0) begin
      $error("%0d result words never arrived", expected_words.size());
      fail_count++;
    end
    $display("Sent %0d words over %0d register settings in %0d cycles.",
             words_sent, phase_no + 1, cycle_count);
    $display("Checked %0d results, %0d with the overpressure trip raised; %0d mismatches.",
             results_checked, trips_seen, fail_count);
    if (fail_count == 0) begin
      $display("stepped_boiler_pressure_power_control regression: pass");
    end else begin
      $display("stepped_boiler_pressure_power_control regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
rtl/sbppc_pkg.sv
rtl/stepped_boiler_pressure_power_control.sv
rtl/sbppc_checker.sv
bench/tb_stepped_boiler_pressure_power_control.sv
